FILE: hw/rtl/base64_stream_encoder_core_defines.svh
// Assertion macros for the checker file of the base64 stream encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BASE64_STREAM_ENCODER_CORE_DEFINES_SVH
`define BASE64_STREAM_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

FILE: hw/rtl/b64e_pkg.sv
// Package for the base64 stream encoder: queue entry type, phase codes,
// character constants and the 6-bit to ASCII mapping. No dependencies.
package b64e_pkg;

    // Queue depth between the front and back parts
    localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

    // Characters per input word, at most
    localparam int unsigned MAX_CHARS = 4;

    localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
    localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
    localparam logic [7:0] CH_LOWER_A = 8'h61; // 'a'
    localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
    localparam logic [7:0] CH_SLASH   = 8'h2F; // '/'

    // Position within the current 3-byte group
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } b64e_phase_t;

    // One decoded input word: up to four sextets, pad marks, last index
    typedef struct packed {
        logic [MAX_CHARS-1:0][5:0] code;
        logic [MAX_CHARS-1:0]      pad;
        logic [1:0]                last_idx;
        logic                      eot;
    } b64e_entry_t;

    // Head of the queue as seen by the back part
    typedef struct packed {
        logic        valid;
        b64e_entry_t entry;
    } b64e_head_t;

    // Map a sextet onto the standard alphabet
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = CH_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            c = CH_LOWER_A + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = CH_ZERO + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/b64e_front.sv
// Front part of the base64 encoder: accepts input words, tracks group phase
// and leftover bits, and builds one queue entry per word. Uses b64e_pkg.
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    input  logic                fifo_full,
    output logic                push,
    output b64e_pkg::b64e_entry_t push_entry
);
    import b64e_pkg::*;

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  pend_reg, pend_next;

    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready;

    // Split the word into sextets and pad marks
    always_comb
    begin
        push_entry = '0;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        unique case (phase_reg)
            PH_SECOND:
            begin
                push_entry.code[0] = {pend_reg[1:0], data_byte[7:4]};
                if (final_byte)
                begin
                    push_entry.code[1] = {data_byte[3:0], 2'b00};
                    push_entry.pad[2]  = 1'b1;
                    push_entry.last_idx = 2'd2;
                end
                phase_next = PH_THIRD;
                pend_next  = data_byte[3:0];
            end
            PH_THIRD:
            begin
                push_entry.code[0]  = {pend_reg, data_byte[7:6]};
                push_entry.code[1]  = data_byte[5:0];
                push_entry.last_idx = 2'd1;
                phase_next = PH_FIRST;
                pend_next  = 4'd0;
            end
            default:
            begin
                // start of group, also the unused phase code
                push_entry.code[0] = data_byte[7:2];
                if (final_byte)
                begin
                    push_entry.code[1] = {data_byte[1:0], 4'b0000};
                    push_entry.pad[2]  = 1'b1;
                    push_entry.pad[3]  = 1'b1;
                    push_entry.last_idx = 2'd3;
                end
                phase_next = PH_SECOND;
                pend_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        push_entry.eot = final_byte;
        // message end returns to the start of a group
        if (final_byte)
        begin
            phase_next = PH_FIRST;
            pend_next  = 4'd0;
        end
    end

    // Group state, advanced per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pend_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: hw/rtl/b64e_fifo.sv
// Short queue of decoded words between front and back parts of the encoder.
// Uses b64e_pkg for the entry type.
module b64e_fifo #(
    parameter int unsigned DEPTH = b64e_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64e_pkg::b64e_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output b64e_pkg::b64e_head_t  head
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64e_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/b64e_back.sv
// Back part of the base64 encoder: walks the head entry one character per
// cycle, unless the output is stalled, into the output register. Uses b64e_pkg.
module b64e_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64e_pkg::b64e_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 last_of_run,
    output logic                 end_of_text
);
    import b64e_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       run_reg, run_next;
    logic       eot_reg, eot_next;
    logic       load;
    logic       is_last;

    assign load    = head.valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == head.entry.last_idx);
    assign pop     = load && is_last;

    // Next output character and index
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        run_next   = run_reg;
        eot_next   = eot_reg;
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = head.entry.pad[idx_reg] ? PAD_CHAR
                                                 : enc_char(head.entry.code[idx_reg]);
            run_next   = is_last;
            eot_next   = is_last && head.entry.eot;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        run_reg  <= run_next;
        eot_reg  <= eot_next;
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign last_of_run = run_reg;
    assign end_of_text = eot_reg;

endmodule

FILE: hw/rtl/base64_stream_encoder_core.sv
// Base64 stream encoder (standard alphabet, '=' padding). One message byte
// per input word, final_byte on the last one; one ASCII character per output
// word. A word gives one or two characters, a final word up to four. The
// output side emits one character per cycle, while out_ready does not stall
// it, from a single output register; the front accepts a word every cycle
// while the FIFO_DEPTH-entry queue has room. A word is written into the
// queue, and its characters then pass through the output register.
// Depends on b64e_pkg, b64e_front, b64e_fifo and b64e_back.
module base64_stream_encoder_core #(
    parameter int unsigned FIFO_DEPTH = b64e_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run,
    output logic       end_of_text
);
    import b64e_pkg::*;

    b64e_entry_t push_entry;
    b64e_head_t  head;
    logic        push;
    logic        pop;
    logic        fifo_full;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text)
    );

endmodule

FILE: hw/rtl/b64e_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_core_defines.svh.
`include "base64_stream_encoder_core_defines.svh"

module b64e_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_of_run,
    input logic       end_of_text
);
    import b64e_pkg::*;

    logic stalled;
    logic char_ok;

    assign stalled = out_valid && !out_ready;
    // every output word is an alphabet character or the pad
    assign char_ok = (out_char >= CH_UPPER_A && out_char <= CH_UPPER_A + 8'd25)
                  || (out_char >= CH_LOWER_A && out_char <= CH_LOWER_A + 8'd25)
                  || (out_char >= CH_ZERO && out_char <= CH_ZERO + 8'd9)
                  || (out_char == CH_PLUS) || (out_char == CH_SLASH)
                  || (out_char == PAD_CHAR);

    // stalled output word holds
    `B64E_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled,
        out_valid && $stable(out_char) && $stable(last_of_run) && $stable(end_of_text))

    `B64E_ASSERT_NOW(a_char_set, clk, rst_n, out_valid, char_ok)

    // message end closes the run of its word
    `B64E_ASSERT_NOW(a_eot_run, clk, rst_n, out_valid && end_of_text, last_of_run)

    // a run that ends in padding ends the message
    `B64E_ASSERT_NOW(a_pad_end, clk, rst_n,
        out_valid && last_of_run && out_char == PAD_CHAR, end_of_text)

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (.*);
